/* src/dq_pkg.sv */
// Shared constants and types for the double-ended queue.
// No dependencies; imported by the top level.
package dq_pkg;

	localparam int unsigned DEPTH    = 16;
	localparam int unsigned IDX_W    = $clog2(DEPTH);
	localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
	localparam int unsigned SUM_W    = CNT_W + 1;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned MODE_W   = 3;
	localparam int unsigned STATUS_W = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_INS_FRONT = 3'd0,
		MODE_INS_REAR  = 3'd1,
		MODE_REM_FRONT = 3'd2,
		MODE_REM_REAR  = 3'd3,
		MODE_LIST      = 3'd4
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_BUSY
	} state_t;

endpackage

/* src/dq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// Read data holds while no read is issued. No dependencies.
module dq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/double_ended_queue.sv */
// Double-ended queue top level: control, ring indices and output register.
// Depends on dq_pkg and dq_ram.
//
// Bounded deque of DEPTH signed 32-bit words in a ring RAM with one registered
// read port. An insert loads its result word when accepted; an unknown mode is
// accepted but returns no word. An insert into a full queue returns status full
// and is dropped. A removal issues the RAM read, then loads the result word; a
// listing reads the stored entries in turn, returning them front to rear with
// last set on the final word. Removing or listing an empty queue returns one
// word with status empty. Input stalls during a removal or listing, and output
// stall holds the result register and stalls the input side.
module double_ended_queue (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [dq_pkg::MODE_W-1:0]           mode,
	input  logic signed [dq_pkg::DATA_W-1:0]    value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [dq_pkg::STATUS_W-1:0]         status,
	output logic signed [dq_pkg::DATA_W-1:0]    data,
	output logic                                last
);

	import dq_pkg::*;

	state_t             state_q, state_d;
	logic [IDX_W-1:0]   front_q, front_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [IDX_W-1:0]   ptr_q, ptr_d;
	logic [CNT_W-1:0]   rem_q, rem_d;

	logic               out_valid_q;
	status_t            out_status_q, out_status_d;
	logic [DATA_W-1:0]  out_data_q, out_data_d;
	logic               out_last_q, out_last_d;
	logic               out_ld;

	logic               ram_we, ram_re;
	logic [IDX_W-1:0]   ram_waddr, ram_raddr;
	logic [DATA_W-1:0]  ram_rdata;

	logic               out_free, accept, full, empty;
	logic [IDX_W-1:0]   front_dec, front_inc, ptr_inc, rear_slot, tail_slot;
	logic [SUM_W-1:0]   rear_sum, tail_sum;

	function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		r = (s >= SUM_W'(DEPTH)) ? s - SUM_W'(DEPTH) : s;
		return r[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	dq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE) || !out_free;
	assign accept    = in_valid && !in_stall;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);

	assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = inc_idx(front_q);
	assign ptr_inc   = inc_idx(ptr_q);
	assign rear_sum  = SUM_W'(front_q) + SUM_W'(count_q);
	assign tail_sum  = rear_sum - 1'b1;
	assign rear_slot = wrap_idx(rear_sum);
	assign tail_slot = wrap_idx(tail_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			ptr_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			ptr_q   <= ptr_d;
			rem_q   <= rem_d;
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			out_status_q <= out_status_d;
			out_data_q   <= out_data_d;
			out_last_q   <= out_last_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		front_d      = front_q;
		count_d      = count_q;
		ptr_d        = ptr_q;
		rem_d        = rem_q;
		ram_we       = 1'b0;
		ram_waddr    = front_dec;
		ram_re       = 1'b0;
		ram_raddr    = front_q;
		out_ld       = 1'b0;
		out_status_d = ST_OK;
		out_data_d   = '0;
		out_last_d   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (mode_t'(mode))
						MODE_INS_FRONT: begin
							out_ld = 1'b1;
							if (full) begin
								out_status_d = ST_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = front_dec;
								front_d   = front_dec;
								count_d   = count_q + 1'b1;
							end
						end
						MODE_INS_REAR: begin
							out_ld = 1'b1;
							if (full) begin
								out_status_d = ST_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = rear_slot;
								count_d   = count_q + 1'b1;
							end
						end
						MODE_REM_FRONT: begin
							if (empty) begin
								out_ld       = 1'b1;
								out_status_d = ST_EMPTY;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = front_q;
								front_d   = front_inc;
								count_d   = count_q - 1'b1;
								rem_d     = CNT_W'(1);
								state_d   = S_BUSY;
							end
						end
						MODE_REM_REAR: begin
							if (empty) begin
								out_ld       = 1'b1;
								out_status_d = ST_EMPTY;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = tail_slot;
								count_d   = count_q - 1'b1;
								rem_d     = CNT_W'(1);
								state_d   = S_BUSY;
							end
						end
						MODE_LIST: begin
							if (empty) begin
								out_ld       = 1'b1;
								out_status_d = ST_EMPTY;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = front_q;
								ptr_d     = front_inc;
								rem_d     = count_q;
								state_d   = S_BUSY;
							end
						end
						default: ;
					endcase
				end
			end
			S_BUSY: begin
				// RAM read data holds until the next read is issued
				if (out_free) begin
					out_ld     = 1'b1;
					out_data_d = ram_rdata;
					out_last_d = (rem_q == CNT_W'(1));
					if (rem_q == CNT_W'(1)) begin
						state_d = S_IDLE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = ptr_q;
						ptr_d     = ptr_inc;
						rem_d     = rem_q - 1'b1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign data      = out_data_q;
	assign last      = out_last_q;

endmodule
